// ===== rtl/sm4_pkg.sv =====
package sm4_pkg;

  localparam int unsigned SM4_ROUNDS = 32;
  localparam int unsigned RND_W      = $clog2(SM4_ROUNDS);
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;

  localparam logic [31:0] SM4_FK [0:3] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SM4_SBOX [0:255] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  typedef enum logic [2:0] {
    ST_KLOAD,
    ST_KEYEXP,
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic key_sched;
  } rnd_ctrl_t;

  function automatic logic [7:0] sm4_sbox(input logic [7:0] v);
    return SM4_SBOX[v];
  endfunction

  // byte j of step i is (4*i + j) * 7 mod 256
  function automatic logic [31:0] sm4_ck(input logic [RND_W-1:0] i);
    logic [31:0] c;
    logic [7:0]  base;
    c    = '0;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      c = {c[23:0], 8'((base + 8'(j)) * 8'd7)};
    end
    return c;
  endfunction

endpackage

// ===== rtl/sm4_round.sv =====
module sm4_round (
  input  sm4_pkg::rnd_ctrl_t ctrl,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  input  logic [31:0]        c,
  input  logic [31:0]        d,
  input  logic [31:0]        k,
  output logic [31:0]        nx
);
  import sm4_pkg::*;

  logic [31:0] t;
  logic [31:0] s;
  logic [31:0] l;

  assign t = b ^ c ^ d ^ k;
  assign s = {sm4_sbox(t[31:24]), sm4_sbox(t[23:16]), sm4_sbox(t[15:8]), sm4_sbox(t[7:0])};

  always_comb begin
    if (ctrl.key_sched) begin
      l = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
    end else begin
      l = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]} ^ {s[13:0], s[31:14]}
            ^ {s[7:0], s[31:8]};
    end
  end

  assign nx = a ^ l;

endmodule

// ===== rtl/sm4_rk_mem.sv =====
module sm4_rk_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [sm4_pkg::RND_W-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [sm4_pkg::RND_W-1:0] raddr,
  output logic [31:0]              rdata
);
  import sm4_pkg::*;

  logic [31:0] mem [0:SM4_ROUNDS-1];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sm4_block_cipher.sv =====
// ST_IDLE takes a block, ST_RUN runs its rounds, ST_FLUSH registers the result when output is free
// one block in flight at a time; one round a cycle through the shared round unit
// key expansion: after reset and after each key word write, no block taken meanwhile
// round keys live in a 32 x 32 memory with a registered read port
// reset (synchronous, rst_n low): key words cleared, then the all-zero key is expanded
module sm4_block_cipher (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [31:0]                  in_word0,
  input  logic [31:0]                  in_word1,
  input  logic [31:0]                  in_word2,
  input  logic [31:0]                  in_word3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  out_word0,
  output logic [31:0]                  out_word1,
  output logic [31:0]                  out_word2,
  output logic [31:0]                  out_word3,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);
  import sm4_pkg::*;

  state_t           state_r, state_nxt;
  logic [RND_W-1:0] cnt_r, cnt_nxt;
  logic             enc_r, enc_nxt;
  logic [31:0]      x_r [0:3];
  logic [31:0]      x_nxt [0:3];
  logic [31:0]      key_r [0:KEY_WORDS-1];
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_r [0:3];

  logic             in_acc;
  logic             cfg_acc;
  logic             cfg_wr_key;
  logic             cnt_last;
  logic             out_free;
  logic             ld_key;
  logic             ld_in;
  logic             do_round;
  logic             ld_out;
  logic             mem_we;
  logic [RND_W-1:0] rd_addr;
  logic [RND_W-1:0] cnt_inc;
  logic [31:0]      rk;
  logic [31:0]      rnd_k;
  logic [31:0]      nx;
  rnd_ctrl_t        rnd_ctrl;

  assign in_acc     = in_valid & ~in_stall;
  assign cfg_acc    = cfg_valid & cfg_ready;
  assign cfg_wr_key = cfg_acc & ((cfg_index == REG_KEY_WORD0) || (cfg_index == REG_KEY_WORD1) ||
                                 (cfg_index == REG_KEY_WORD2) || (cfg_index == REG_KEY_WORD3));
  assign cnt_last   = cnt_r == RND_W'(SM4_ROUNDS - 1);
  assign out_free   = ~out_valid_r | ~out_stall;
  assign cnt_inc    = cnt_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_KLOAD:  state_nxt = ST_KEYEXP;
      ST_KEYEXP: begin
        if (cfg_wr_key) begin
          state_nxt = ST_KLOAD;
        end else if (cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_wr_key) begin
          state_nxt = ST_KLOAD;
        end else if (in_acc) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_KLOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall           = 1'b1;
    cfg_ready          = 1'b0;
    ld_key             = 1'b0;
    ld_in              = 1'b0;
    do_round           = 1'b0;
    ld_out             = 1'b0;
    mem_we             = 1'b0;
    rnd_ctrl.key_sched = 1'b0;
    rd_addr            = enc_r ? cnt_inc : ~cnt_inc;
    unique case (state_r)
      ST_KLOAD: begin
        ld_key = 1'b1;
      end
      ST_KEYEXP: begin
        cfg_ready          = 1'b1;
        do_round           = ~cfg_wr_key;
        mem_we             = ~cfg_wr_key;
        rnd_ctrl.key_sched = 1'b1;
      end
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        ld_in     = in_acc;
        rd_addr   = in_mode ? '0 : '1;
      end
      ST_RUN: begin
        do_round = 1'b1;
      end
      ST_FLUSH: begin
        ld_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign rnd_k = rnd_ctrl.key_sched ? sm4_ck(cnt_r) : rk;

  sm4_round u_round (
    .ctrl (rnd_ctrl),
    .a    (x_r[0]),
    .b    (x_r[1]),
    .c    (x_r[2]),
    .d    (x_r[3]),
    .k    (rnd_k),
    .nx   (nx)
  );

  sm4_rk_mem u_rk_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r),
    .wdata (nx),
    .raddr (rd_addr),
    .rdata (rk)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    enc_nxt = enc_r;
    for (int i = 0; i < 4; i++) begin
      x_nxt[i] = x_r[i];
    end
    if (ld_key) begin
      cnt_nxt = '0;
      for (int i = 0; i < 4; i++) begin
        x_nxt[i] = key_r[i] ^ SM4_FK[i];
      end
    end else if (ld_in) begin
      cnt_nxt  = '0;
      enc_nxt  = in_mode;
      x_nxt[0] = in_word0;
      x_nxt[1] = in_word1;
      x_nxt[2] = in_word2;
      x_nxt[3] = in_word3;
    end else if (do_round) begin
      cnt_nxt  = cnt_inc;
      x_nxt[0] = x_r[1];
      x_nxt[1] = x_r[2];
      x_nxt[2] = x_r[3];
      x_nxt[3] = nx;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KLOAD;
      cnt_r       <= '0;
      enc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      enc_r       <= enc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_key) begin
        key_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      x_r[i] <= x_nxt[i];
    end
    if (ld_out) begin
      for (int i = 0; i < 4; i++) begin
        out_r[i] <= x_r[3-i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word0 = out_r[0];
  assign out_word1 = out_r[1];
  assign out_word2 = out_r[2];
  assign out_word3 = out_r[3];

endmodule

// ===== rtl/sm4_chk.sv =====
module sm4_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [31:0]                  out_word0,
  input logic [31:0]                  out_word3,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index
);
  import sm4_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word0) && $stable(out_word3))
    else $error("result changed while stalled");

  // busy right after a block is taken
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block taken while a block is in flight");

  // still running the rounds when checked after a block is taken
  a_busy_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##32 in_stall)
    else $error("block finished too early");

  // a key word write starts the key expansion
  a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_KEY_WORD0 || cfg_index == REG_KEY_WORD1 ||
    cfg_index == REG_KEY_WORD2 || cfg_index == REG_KEY_WORD3) |=> in_stall)
    else $error("block taken during key expansion");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word0 (out_word0),
  .out_word3 (out_word3),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index)
);
